// File: hw/rtl/tpt_pkg.sv
// Shared types, constants and helpers for the TLB / page table translator.
package tpt_pkg;

   localparam int ADDR_W  = 16;
   localparam int TAG_W   = 8;
   localparam int FRAME_W = 8;
   localparam int COUNT_W = 16;
   localparam int FREE_W  = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [FREE_W-1:0]  FREE_MAX  = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MEM
   } state_type;

   // one TLB slot
   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [FRAME_W-1:0] frame;
   } tlb_entry_type;

   // lookup answer of one slot or of the whole TLB; frame is zero without a hit
   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame;
   } tlb_match_type;

   // one page table word
   typedef struct packed {
      logic               present;
      logic [FRAME_W-1:0] frame;
   } pt_entry_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
   endfunction

endpackage

// File: hw/rtl/tlb_page_table_translator.sv
// Top level: virtual to physical translation through a FIFO TLB and a demand-paged table.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-------------------------------------------
//  req      | in  | req_tvalid/req_tready  | req_tdata: virtual_address
//  rsp      | out | rsp_tvalid/rsp_tready  | rsp_tdata: physical_address, hit_total,
//           |     |                        |   miss_total, fault_total
//           |     |                        | rsp_tuser: tlb_hit, page_fault
//
//  A TLB hit goes from accept to result through a tag compare in the slot row.
//  A miss also reads the page table: the read port is single and its read data is registered.
//  After reset the page table is swept clear, with req_tready low.
//  One word is in flight at a time; the next is accepted while a result still waits.
//  A held result stalls completion of the next word, never its accept.
module tlb_page_table_translator
   import tpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int OFFSET_BITS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] virtual_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] physical_address, [31:16] hit_total,
                                    // [47:32] miss_total, [63:48] fault_total
   output logic [1:0]  rsp_tuser    // [0] tlb_hit, [1] page_fault
);

   localparam int PAGE_W = $clog2(PAGE_COUNT);
   localparam int FBITS  = ADDR_W - OFFSET_BITS;
   localparam logic [FRAME_W-1:0] FMASK =
      (FBITS >= FRAME_W) ? '1 : FRAME_W'((32'd1 << FBITS) - 32'd1);
   localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((32'd1 << OFFSET_BITS) - 32'd1);
   localparam logic [ADDR_W-1:0] PAGE_CNT_V = ADDR_W'(PAGE_COUNT);

   // page modulo by reciprocal: quotient estimate is exact or one short
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 25;
   localparam int PROD_W      = ADDR_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((32'd1 << RECIP_SHIFT) / PAGE_COUNT);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    va_ff;
   logic [ADDR_W-1:0]    quot_ff;

   logic [COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic [COUNT_W-1:0]   fault_cnt_ff, fault_cnt_in;
   logic [FREE_W-1:0]    next_free_ff, next_free_in;

   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    phys_ff, phys_in;
   logic                 hit_ff, hit_in;
   logic                 fault_ff, fault_in;
   logic                 load_w;
   logic                 out_free_w;

   logic [ADDR_W-1:0]    req_page_w;
   logic [PROD_W-1:0]    prod_w;
   logic [ADDR_W-1:0]    va_page_w;
   logic [2*ADDR_W-1:0]  qp_w;
   logic [ADDR_W-1:0]    rem_w;
   logic [ADDR_W-1:0]    rem_fix_w;
   logic [PAGE_W-1:0]    page_w;
   logic [TAG_W-1:0]     tag_w;
   logic [FRAME_W-1:0]   frame_w;
   logic [23:0]          phys_wide_w;

   tlb_match_type        lookup_w;
   tlb_entry_type        fill_w;
   logic                 tlb_shift_w;

   pt_entry_type         pt_rd_w;
   pt_entry_type         pt_wr_w;
   logic                 pt_rd_en_w;
   logic                 pt_wr_en_w;
   logic                 pt_ready_w;

   // quotient estimate is formed on accept, so its multiply ends in a register
   assign req_page_w = ADDR_W'(req_tdata >> OFFSET_BITS);
   assign prod_w     = PROD_W'(req_page_w) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         va_ff   <= req_tdata;
         quot_ff <= prod_w[RECIP_SHIFT +: ADDR_W];
      end
   end

   // page number modulo PAGE_COUNT, tag is its low byte
   assign va_page_w = ADDR_W'(va_ff >> OFFSET_BITS);
   assign qp_w      = (2*ADDR_W)'(quot_ff) * (2*ADDR_W)'(PAGE_CNT_V);
   assign rem_w     = va_page_w - qp_w[ADDR_W-1:0];
   assign rem_fix_w = (rem_w >= PAGE_CNT_V) ? rem_w - PAGE_CNT_V : rem_w;
   assign page_w    = rem_fix_w[PAGE_W-1:0];
   assign tag_w     = TAG_W'(page_w);

   tpt_tlb #(
      .TLB_ENTRIES (TLB_ENTRIES)
   ) u_tlb (
      .clock      (clock),
      .reset      (reset),
      .shift      (tlb_shift_w),
      .fill       (fill_w),
      .lookup_tag (tag_w),
      .result     (lookup_w)
   );

   tpt_page_table #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_page_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (pt_rd_en_w),
      .wr_en   (pt_wr_en_w),
      .addr    (page_w),
      .wr_data (pt_wr_w),
      .rd_data (pt_rd_w),
      .ready   (pt_ready_w)
   );

   assign out_free_w = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      load_w       = 1'b0;
      hit_in       = 1'b0;
      fault_in     = 1'b0;
      frame_w      = lookup_w.frame;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      next_free_in = next_free_ff;
      pt_rd_en_w   = 1'b0;
      pt_wr_en_w   = 1'b0;
      tlb_shift_w  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = pt_ready_w;
            if (req_tvalid && pt_ready_w) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (lookup_w.hit) begin
               if (out_free_w) begin
                  load_w     = 1'b1;
                  hit_in     = 1'b1;
                  hit_cnt_in = sat_inc(hit_cnt_ff);
                  state_in   = ST_IDLE;
               end
            end else begin
               pt_rd_en_w = 1'b1;
               state_in   = ST_MEM;
            end
         end
         ST_MEM: begin
            frame_w = pt_rd_w.frame;
            if (out_free_w) begin
               load_w      = 1'b1;
               tlb_shift_w = 1'b1;
               miss_cnt_in = sat_inc(miss_cnt_ff);
               if (!pt_rd_w.present) begin
                  // demand fill: next free frame, wrapped to the frame field
                  frame_w      = next_free_ff[FRAME_W-1:0] & FMASK;
                  fault_in     = 1'b1;
                  pt_wr_en_w   = 1'b1;
                  fault_cnt_in = sat_inc(fault_cnt_ff);
                  if (next_free_ff != FREE_MAX) begin
                     next_free_in = next_free_ff + 1'b1;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pt_wr_w.present = 1'b1;
   assign pt_wr_w.frame   = frame_w;
   assign fill_w.valid    = 1'b1;
   assign fill_w.tag      = tag_w;
   assign fill_w.frame    = frame_w;

   assign phys_wide_w = (24'(frame_w) << OFFSET_BITS) | 24'(va_ff & OFF_MASK);
   assign phys_in     = phys_wide_w[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         fault_cnt_ff <= '0;
         next_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         next_free_ff <= next_free_in;
         if (load_w) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_w) begin
         phys_ff  <= phys_in;
         hit_ff   <= hit_in;
         fault_ff <= fault_in;
      end
   end

   // counters only move when a new result is loaded, so they feed the word directly
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {fault_cnt_ff, miss_cnt_ff, hit_cnt_ff, phys_ff};
   assign rsp_tuser  = {fault_ff, hit_ff};

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_LOOK || $past(state_ff) == ST_MEM))
      else $error("result appeared without a lookup or table cycle");

   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(hit_ff && fault_ff))
      else $error("word flagged as both TLB hit and page fault");

   a_fault_le_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fault_cnt_ff <= miss_cnt_ff))
      else $error("fault count ran ahead of miss count");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      !pt_ready_w |-> !req_tready)
      else $error("word accepted during page table clear");

endmodule

// File: hw/rtl/tpt_tlb_cell.sv
// One TLB slot: holds an entry, shifts it on to the next slot on a fill, compares a tag.
module tpt_tlb_cell
   import tpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  tlb_entry_type      entry_in,
   output tlb_entry_type      entry_out,
   input  logic [TAG_W-1:0]   lookup_tag,
   output tlb_match_type      match
);

   logic                valid_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [FRAME_W-1:0]  frame_ff;
   logic                hit_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         tag_ff   <= entry_in.tag;
         frame_ff <= entry_in.frame;
      end
   end

   assign hit_w           = valid_ff && (tag_ff == lookup_tag);
   assign match.hit       = hit_w;
   assign match.frame     = frame_ff & {FRAME_W{hit_w}};
   assign entry_out.valid = valid_ff;
   assign entry_out.tag   = tag_ff;
   assign entry_out.frame = frame_ff;

endmodule

// File: hw/rtl/tpt_tlb.sv
// Row of TLB slots; a fill enters slot 0 and the oldest entry drops off the far end.
module tpt_tlb
   import tpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  tlb_entry_type    fill,
   input  logic [TAG_W-1:0] lookup_tag,
   output tlb_match_type    result
);

   tlb_entry_type              chain_w [TLB_ENTRIES+1];
   tlb_match_type              match_w [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0]     hits_w;

   assign chain_w[0] = fill;

   for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
      tpt_tlb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .entry_in   (chain_w[i]),
         .entry_out  (chain_w[i+1]),
         .lookup_tag (lookup_tag),
         .match      (match_w[i])
      );
      assign hits_w[i] = match_w[i].hit;
   end

   // tags never repeat, so at most one slot answers and an OR picks its frame
   always_comb begin
      result = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         result.hit   = result.hit | match_w[i].hit;
         result.frame = result.frame | match_w[i].frame;
      end
   end

   a_single_hit: assert property (@(posedge clock) disable iff (reset) $onehot0(hits_w))
      else $error("more than one TLB slot matches the lookup tag");

endmodule

// File: hw/rtl/tpt_page_table.sv
// Page table memory with present bits, cleared by a sweep after reset.
module tpt_page_table
   import tpt_pkg::*;
#(
   parameter int PAGE_COUNT = 256
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic                          wr_en,
   input  logic [$clog2(PAGE_COUNT)-1:0] addr,
   input  pt_entry_type                  wr_data,
   output pt_entry_type                  rd_data,
   output logic                          ready
);

   localparam int PAGE_W = $clog2(PAGE_COUNT);
   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGE_COUNT - 1);

   pt_entry_type        mem [PAGE_COUNT];
   pt_entry_type        rd_data_ff;
   logic [PAGE_W-1:0]   clear_ff;
   logic                clearing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clear_ff    <= '0;
      end else if (clearing_ff) begin
         clear_ff <= clear_ff + 1'b1;
         if (clear_ff == LAST_PAGE) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_ff] <= '0;
      end else if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

endmodule
